// ----- hdl/ohlcv_bar_aggregator_defines.svh -----
// assertion macros shared by the ohlcv bar aggregator sources
`ifndef OHLCV_BAR_AGGREGATOR_DEFINES_SVH
`define OHLCV_BAR_AGGREGATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define OBAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("obag assertion failed");
`define OBAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("obag assertion failed");
`else
`define OBAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define OBAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/obag_pkg.sv -----
// shared constants, codes and width helpers of the ohlcv bar aggregator
`timescale 1ns / 1ps
package obag_pkg;

	localparam int FIELD_W              = 24;
	localparam int TIME_W               = 63;
	localparam int VALUE_W              = 64;
	localparam int PV_W                 = 64;
	localparam int NUM_STATS            = 15;
	localparam int BAR_QUEUE_DEPTH      = 2;
	localparam int OBAG_MAX_TRADES_LOG2 = 16;
	localparam int OBAG_PRICE_BITS      = 24;

	typedef enum logic [3:0] {
		ID_OPEN     = 4'd0,
		ID_CLOSE    = 4'd1,
		ID_HIGH     = 4'd2,
		ID_LOW      = 4'd3,
		ID_VOL      = 4'd4,
		ID_SIZE     = 4'd5,
		ID_TICK_VOL = 4'd6,
		ID_TICK_SZ  = 4'd7,
		ID_SIDE_VOL = 4'd8,
		ID_SIDE_SZ  = 4'd9,
		ID_VWAP     = 4'd10,
		ID_START    = 4'd11,
		ID_STOP     = 4'd12,
		ID_DURATION = 4'd13,
		ID_COUNT    = 4'd14
	} stat_id_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ORDER    = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_ZERO_VOL = 2'd3
	} bar_status_t;

	localparam logic [1:0] DIR_BUY  = 2'b01;
	localparam logic [1:0] DIR_SELL = 2'b11;

	function automatic int price_width(input int price_bits);
		return (price_bits < FIELD_W) ? price_bits : FIELD_W;
	endfunction

	function automatic int sum_width(input int max_log2);
		return FIELD_W + max_log2;
	endfunction

	function automatic int rec_bits(input int max_log2, input int price_bits);
		int pw;
		int vw;
		pw = price_width(price_bits);
		vw = sum_width(max_log2);
		return 4 * pw + 2 * vw + 4 * (vw + 1) + PV_W + 2 * TIME_W + (max_log2 + 1) + 2;
	endfunction

endpackage

// ----- hdl/obag_if.sv -----
// trade and statistic channel interfaces
`timescale 1ns / 1ps
interface obag_trade_if;
	logic               valid;
	logic               ready;
	logic [23:0]        trade_price;
	logic [23:0]        trade_volume;
	logic [23:0]        trade_size;
	logic signed [1:0]  trade_direction;
	logic [62:0]        trade_time;
	logic               bar_end;

	modport source (
		output valid, trade_price, trade_volume, trade_size, trade_direction,
			trade_time, bar_end,
		input ready
	);
	modport sink (
		input valid, trade_price, trade_volume, trade_size, trade_direction,
			trade_time, bar_end,
		output ready
	);
endinterface

interface obag_stat_if;
	logic               valid;
	logic               ready;
	logic [3:0]         stat_id;
	logic signed [63:0] stat_value;
	logic [1:0]         bar_status;
	logic               stat_last;

	modport source (
		output valid, stat_id, stat_value, bar_status, stat_last,
		input ready
	);
	modport sink (
		input valid, stat_id, stat_value, bar_status, stat_last,
		output ready
	);
endinterface

// ----- hdl/obag_front.sv -----
// trade intake: price times volume stage, then per-bar accumulators
`timescale 1ns / 1ps
module obag_front import obag_pkg::*; #(
	parameter int MAX_TRADES_LOG2 = OBAG_MAX_TRADES_LOG2,
	parameter int PRICE_BITS      = OBAG_PRICE_BITS
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	obag_trade_if.sink                                    trades,
	output logic                                          rec_push,
	output logic [rec_bits(MAX_TRADES_LOG2, PRICE_BITS)-1:0] rec_data,
	input  logic                                          rec_full
);

	localparam int PW     = price_width(PRICE_BITS);
	localparam int VW     = sum_width(MAX_TRADES_LOG2);
	localparam int CW     = MAX_TRADES_LOG2 + 1;
	localparam int PROD_W = PW + FIELD_W;

	typedef struct packed {
		logic [PW-1:0]     open_price;
		logic [PW-1:0]     close_price;
		logic [PW-1:0]     high_price;
		logic [PW-1:0]     low_price;
		logic [VW-1:0]     vol_sum;
		logic [VW-1:0]     size_sum;
		logic [VW:0]       tick_vol;
		logic [VW:0]       tick_size;
		logic [VW:0]       side_vol;
		logic [VW:0]       side_size;
		logic [PV_W-1:0]   pv_sum;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] stop_time;
		logic [CW-1:0]     trade_count;
		bar_status_t       fault;
	} bar_rec_t;

	// stage 1
	logic               valid_s1;
	logic [PW-1:0]      price_s1;
	logic [FIELD_W-1:0] vol_s1;
	logic [FIELD_W-1:0] size_s1;
	logic [1:0]         dir_s1;
	logic [TIME_W-1:0]  time_s1;
	logic               last_s1;
	logic [PROD_W-1:0]  pv_s1;

	// bar accumulators
	logic              in_bar_q,      in_bar_d;
	logic [PW-1:0]     open_q,        open_d;
	logic [PW-1:0]     high_q,        high_d;
	logic [PW-1:0]     low_q,         low_d;
	logic [PW-1:0]     prev_price_q,  prev_price_d;
	logic [TIME_W-1:0] start_q,       start_d;
	logic [TIME_W-1:0] prev_time_q,   prev_time_d;
	logic [VW-1:0]     vol_q,         vol_d;
	logic [VW-1:0]     size_q,        size_d;
	logic [VW:0]       tick_vol_q,    tick_vol_d;
	logic [VW:0]       tick_size_q,   tick_size_d;
	logic [VW:0]       side_vol_q,    side_vol_d;
	logic [VW:0]       side_size_q,   side_size_d;
	logic [PV_W-1:0]   pv_q,          pv_d;
	logic [CW-1:0]     count_q,       count_d;
	bar_status_t       fault_q,       fault_d;

	logic          advance;
	logic          drop;
	logic [VW:0]   vol_x;
	logic [VW:0]   size_x;
	bar_rec_t      rec;

	assign advance      = valid_s1 && (!last_s1 || !rec_full);
	assign trades.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (trades.ready) begin
			valid_s1 <= trades.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (trades.valid && trades.ready) begin
			price_s1 <= trades.trade_price[PW-1:0];
			vol_s1   <= trades.trade_volume;
			size_s1  <= trades.trade_size;
			dir_s1   <= trades.trade_direction;
			time_s1  <= trades.trade_time;
			last_s1  <= trades.bar_end;
			pv_s1    <= {{FIELD_W{1'b0}}, trades.trade_price[PW-1:0]}
				* {{PW{1'b0}}, trades.trade_volume};
		end
	end

	assign vol_x  = {{(VW + 1 - FIELD_W){1'b0}}, vol_s1};
	assign size_x = {{(VW + 1 - FIELD_W){1'b0}}, size_s1};

	always_comb begin
		in_bar_d     = in_bar_q;
		open_d       = open_q;
		high_d       = high_q;
		low_d        = low_q;
		prev_price_d = prev_price_q;
		start_d      = start_q;
		prev_time_d  = prev_time_q;
		vol_d        = vol_q;
		size_d       = size_q;
		tick_vol_d   = tick_vol_q;
		tick_size_d  = tick_size_q;
		side_vol_d   = side_vol_q;
		side_size_d  = side_size_q;
		pv_d         = pv_q;
		count_d      = count_q;
		fault_d      = fault_q;
		drop         = 1'b0;

		if (!in_bar_q) begin
			in_bar_d = 1'b1;
			open_d   = price_s1;
			high_d   = price_s1;
			low_d    = price_s1;
			start_d  = time_s1;
		end else if (count_q[CW-1]) begin
			// bar full, trade dropped
			drop = 1'b1;
			if (fault_q == ST_OK) begin
				fault_d = ST_OVERFLOW;
			end
		end else begin
			if ((time_s1 < prev_time_q) && (fault_q == ST_OK)) begin
				fault_d = ST_ORDER;
			end
			if (price_s1 > high_q) begin
				high_d = price_s1;
			end
			if (price_s1 < low_q) begin
				low_d = price_s1;
			end
			if (price_s1 > prev_price_q) begin
				tick_vol_d  = tick_vol_q + vol_x;
				tick_size_d = tick_size_q + size_x;
			end else if (price_s1 < prev_price_q) begin
				tick_vol_d  = tick_vol_q - vol_x;
				tick_size_d = tick_size_q - size_x;
			end
		end

		if (!drop) begin
			vol_d        = vol_q + vol_x[VW-1:0];
			size_d       = size_q + size_x[VW-1:0];
			pv_d         = pv_q + PV_W'(pv_s1);
			count_d      = count_q + CW'(1);
			prev_price_d = price_s1;
			prev_time_d  = time_s1;
			if (dir_s1 == DIR_BUY) begin
				side_vol_d  = side_vol_q + vol_x;
				side_size_d = side_size_q + size_x;
			end else if (dir_s1 == DIR_SELL) begin
				side_vol_d  = side_vol_q - vol_x;
				side_size_d = side_size_q - size_x;
			end
		end
	end

	always_comb begin
		rec.open_price  = open_d;
		rec.close_price = prev_price_d;
		rec.high_price  = high_d;
		rec.low_price   = low_d;
		rec.vol_sum     = vol_d;
		rec.size_sum    = size_d;
		rec.tick_vol    = tick_vol_d;
		rec.tick_size   = tick_size_d;
		rec.side_vol    = side_vol_d;
		rec.side_size   = side_size_d;
		rec.pv_sum      = pv_d;
		rec.start_time  = start_d;
		rec.stop_time   = prev_time_d;
		rec.trade_count = count_d;
		rec.fault       = fault_d;
	end

	assign rec_push = advance && last_s1;
	assign rec_data = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bar_q     <= 1'b0;
			open_q       <= '0;
			high_q       <= '0;
			low_q        <= '0;
			prev_price_q <= '0;
			start_q      <= '0;
			prev_time_q  <= '0;
			vol_q        <= '0;
			size_q       <= '0;
			tick_vol_q   <= '0;
			tick_size_q  <= '0;
			side_vol_q   <= '0;
			side_size_q  <= '0;
			pv_q         <= '0;
			count_q      <= '0;
			fault_q      <= ST_OK;
		end else if (advance) begin
			if (last_s1) begin
				// bar closed, start afresh
				in_bar_q     <= 1'b0;
				open_q       <= '0;
				high_q       <= '0;
				low_q        <= '0;
				prev_price_q <= '0;
				start_q      <= '0;
				prev_time_q  <= '0;
				vol_q        <= '0;
				size_q       <= '0;
				tick_vol_q   <= '0;
				tick_size_q  <= '0;
				side_vol_q   <= '0;
				side_size_q  <= '0;
				pv_q         <= '0;
				count_q      <= '0;
				fault_q      <= ST_OK;
			end else begin
				in_bar_q     <= in_bar_d;
				open_q       <= open_d;
				high_q       <= high_d;
				low_q        <= low_d;
				prev_price_q <= prev_price_d;
				start_q      <= start_d;
				prev_time_q  <= prev_time_d;
				vol_q        <= vol_d;
				size_q       <= size_d;
				tick_vol_q   <= tick_vol_d;
				tick_size_q  <= tick_size_d;
				side_vol_q   <= side_vol_d;
				side_size_q  <= side_size_d;
				pv_q         <= pv_d;
				count_q      <= count_d;
				fault_q      <= fault_d;
			end
		end
	end

endmodule

// ----- hdl/obag_bar_fifo.sv -----
// short queue of closed bar records between intake and emission
`timescale 1ns / 1ps
`include "ohlcv_bar_aggregator_defines.svh"
module obag_bar_fifo import obag_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = BAR_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`OBAG_ASSERT_NOW(a_no_push_when_full, clk, arst_n, wr_en, !full)
	`OBAG_ASSERT_NOW(a_no_pop_when_empty, clk, arst_n, rd_en, !empty)
	`OBAG_ASSERT_NEXT(a_count_grows, clk, arst_n, (wr_en && !rd_en), (count_q == $past(count_q) + CNT_W'(1)))

endmodule

// ----- hdl/obag_divider.sv -----
// restoring divider, one quotient bit per clock
`timescale 1ns / 1ps
module obag_divider #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign fits     = (trial >= {1'b0, den_q});
	assign done     = done_q;
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
				num_q  <= numer;
				rem_q  <= '0;
				den_q  <= denom;
			end else if (busy_q) begin
				rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/obag_back.sv -----
// bar close: vwap division and the fifteen statistic words
`timescale 1ns / 1ps
`include "ohlcv_bar_aggregator_defines.svh"
module obag_back import obag_pkg::*; #(
	parameter int MAX_TRADES_LOG2 = OBAG_MAX_TRADES_LOG2,
	parameter int PRICE_BITS      = OBAG_PRICE_BITS
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic [rec_bits(MAX_TRADES_LOG2, PRICE_BITS)-1:0] rec_data,
	input  logic                                          rec_empty,
	output logic                                          rec_pop,
	obag_stat_if.source                                   stats
);

	localparam int PW = price_width(PRICE_BITS);
	localparam int VW = sum_width(MAX_TRADES_LOG2);
	localparam int CW = MAX_TRADES_LOG2 + 1;

	typedef struct packed {
		logic [PW-1:0]     open_price;
		logic [PW-1:0]     close_price;
		logic [PW-1:0]     high_price;
		logic [PW-1:0]     low_price;
		logic [VW-1:0]     vol_sum;
		logic [VW-1:0]     size_sum;
		logic [VW:0]       tick_vol;
		logic [VW:0]       tick_size;
		logic [VW:0]       side_vol;
		logic [VW:0]       side_size;
		logic [PV_W-1:0]   pv_sum;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] stop_time;
		logic [CW-1:0]     trade_count;
		bar_status_t       fault;
	} bar_rec_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EMIT
	} state_t;

	state_t               state_q;
	bar_rec_t             rec_in;
	bar_rec_t             rec_q;
	bar_status_t          bar_status_q;
	logic [PV_W-1:0]      vwap_q;
	stat_id_t             idx_q;
	logic                 valid_q;
	stat_id_t             sid_q;
	logic [VALUE_W-1:0]   value_q;
	bar_status_t          status_q;
	logic                 last_q;
	logic [VALUE_W-1:0]   word;
	logic                 out_load;
	logic                 div_done;
	logic [PV_W-1:0]      div_quot;

	assign rec_in   = bar_rec_t'(rec_data);
	assign rec_pop  = (state_q == S_IDLE) && !rec_empty;
	assign out_load = (state_q == S_EMIT) && (!valid_q || stats.ready);

	obag_divider #(
		.NUM_W (PV_W),
		.DEN_W (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rec_pop),
		.numer    (rec_in.pv_sum),
		.denom    (rec_in.vol_sum),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		unique case (idx_q)
			ID_OPEN:     word = VALUE_W'(rec_q.open_price);
			ID_CLOSE:    word = VALUE_W'(rec_q.close_price);
			ID_HIGH:     word = VALUE_W'(rec_q.high_price);
			ID_LOW:      word = VALUE_W'(rec_q.low_price);
			ID_VOL:      word = VALUE_W'(rec_q.vol_sum);
			ID_SIZE:     word = VALUE_W'(rec_q.size_sum);
			ID_TICK_VOL: word = {{(VALUE_W - VW - 1){rec_q.tick_vol[VW]}}, rec_q.tick_vol};
			ID_TICK_SZ:  word = {{(VALUE_W - VW - 1){rec_q.tick_size[VW]}}, rec_q.tick_size};
			ID_SIDE_VOL: word = {{(VALUE_W - VW - 1){rec_q.side_vol[VW]}}, rec_q.side_vol};
			ID_SIDE_SZ:  word = {{(VALUE_W - VW - 1){rec_q.side_size[VW]}}, rec_q.side_size};
			ID_VWAP:     word = vwap_q;
			ID_START:    word = {1'b0, rec_q.start_time};
			ID_STOP:     word = {1'b0, rec_q.stop_time};
			ID_DURATION: word = {1'b0, rec_q.stop_time} - {1'b0, rec_q.start_time};
			ID_COUNT:    word = VALUE_W'(rec_q.trade_count);
			default:     word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rec_q        <= '0;
			bar_status_q <= ST_OK;
			vwap_q       <= '0;
			idx_q        <= ID_OPEN;
			valid_q      <= 1'b0;
			sid_q        <= ID_OPEN;
			value_q      <= '0;
			status_q     <= ST_OK;
			last_q       <= 1'b0;
		end else begin
			if (valid_q && stats.ready && !out_load) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rec_pop) begin
						rec_q   <= rec_in;
						state_q <= S_DIV;
						if ((rec_in.fault == ST_OK) && (rec_in.vol_sum == '0)) begin
							bar_status_q <= ST_ZERO_VOL;
						end else begin
							bar_status_q <= rec_in.fault;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						vwap_q  <= (rec_q.vol_sum == '0) ? '0 : div_quot;
						idx_q   <= ID_OPEN;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						valid_q  <= 1'b1;
						sid_q    <= idx_q;
						value_q  <= word;
						status_q <= bar_status_q;
						last_q   <= (idx_q == ID_COUNT);
						if (idx_q == ID_COUNT) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= stat_id_t'(idx_q + 4'd1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stats.valid      = valid_q;
	assign stats.stat_id    = sid_q;
	assign stats.stat_value = value_q;
	assign stats.bar_status = status_q;
	assign stats.stat_last  = last_q;

	`OBAG_ASSERT_NOW(a_last_on_count, clk, arst_n, valid_q, (last_q == (sid_q == ID_COUNT)))
	`OBAG_ASSERT_NEXT(a_words_in_order, clk, arst_n, (valid_q && stats.ready && !last_q), (valid_q && (4'(sid_q) == 4'($past(sid_q)) + 4'd1)))
	`OBAG_ASSERT_NOW(a_div_done_in_div, clk, arst_n, div_done, (state_q == S_DIV))

endmodule

// ----- hdl/ohlcv_bar_aggregator.sv -----
// top level of the ohlcv bar aggregator
`timescale 1ns / 1ps
// Takes one trade per clock with no gaps while bars are long: a trade passes a
// price times volume register, then updates the bar accumulators. The trade
// marked bar_end closes the bar and its record enters a two-entry queue. The
// emission side takes one record at a time: it loads the record, runs the
// one-bit-per-clock vwap divider, then sends the fifteen words ids 0 to 14 at
// one per clock while the sink is ready. Bars shorter than the emission of one
// record, sustained, fill the queue and the input then stalls on the next
// bar_end trade until a record is drained.
module ohlcv_bar_aggregator import obag_pkg::*; #(
	parameter int MAX_TRADES_LOG2 = OBAG_MAX_TRADES_LOG2,
	parameter int PRICE_BITS      = OBAG_PRICE_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	obag_trade_if.sink   trades,
	obag_stat_if.source  stats
);

	localparam int REC_W = rec_bits(MAX_TRADES_LOG2, PRICE_BITS);

	logic             rec_push;
	logic [REC_W-1:0] rec_wr_data;
	logic             rec_full;
	logic             rec_pop;
	logic [REC_W-1:0] rec_rd_data;
	logic             rec_empty;

	obag_front #(
		.MAX_TRADES_LOG2 (MAX_TRADES_LOG2),
		.PRICE_BITS      (PRICE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.trades   (trades),
		.rec_push (rec_push),
		.rec_data (rec_wr_data),
		.rec_full (rec_full)
	);

	obag_bar_fifo #(
		.WIDTH (REC_W),
		.DEPTH (BAR_QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec_wr_data),
		.full    (rec_full),
		.rd_en   (rec_pop),
		.rd_data (rec_rd_data),
		.empty   (rec_empty)
	);

	obag_back #(
		.MAX_TRADES_LOG2 (MAX_TRADES_LOG2),
		.PRICE_BITS      (PRICE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_data  (rec_rd_data),
		.rec_empty (rec_empty),
		.rec_pop   (rec_pop),
		.stats     (stats)
	);

endmodule
